/* src/ssrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_pkg: shared types and constants of the soft-start ramp controller
// Request and result structures, mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ssrc_pkg;

	// Field widths
	localparam int TIMER_W = 20;
	localparam int LEVEL_W = 10;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 2;

	// Reset timing, in 1 us ticks and milliseconds
	localparam int unsigned RAMP_TIME_MS   = 5000;
	localparam int unsigned RAMP_STEP_MS   = 10;
	localparam int unsigned DEBOUNCE_RESET = 20000;
	localparam logic [TIMER_W-1:0] DEBOUNCE_INIT = TIMER_W'(DEBOUNCE_RESET);
	localparam logic [TIMER_W-1:0] INTERVAL_INIT = TIMER_W'(RAMP_STEP_MS * 1000);
	localparam logic [LEVEL_W-1:0] STEPS_INIT    = LEVEL_W'(RAMP_TIME_MS / RAMP_STEP_MS);

	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 2'd2;

	// Reported mode codes
	localparam logic [MODE_W-1:0] CODE_OFF  = 2'd0;
	localparam logic [MODE_W-1:0] CODE_UP   = 2'd1;
	localparam logic [MODE_W-1:0] CODE_RUN  = 2'd2;
	localparam logic [MODE_W-1:0] CODE_DOWN = 2'd3;

	typedef enum logic [3:0] {
		MODE_OFF  = 4'b0001,
		MODE_UP   = 4'b0010,
		MODE_RUN  = 4'b0100,
		MODE_DOWN = 4'b1000
	} mode_t;

	typedef struct packed {
		logic toggle_button_low;
		logic kill_button_low;
		logic start_request;
		logic stop_request;
	} in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] amplitude_level;
		logic               output_enabled;
		logic               led_on;
		logic [MODE_W-1:0]  device_mode;
		logic               on_pulse;
		logic               off_pulse;
	} out_t;

	// Saturating increment of a tick counter
	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		return (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_W'(1);
	endfunction

	// Map the one-hot state onto the reported code
	function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
		logic [MODE_W-1:0] c;
		unique case (m)
			MODE_OFF:  c = CODE_OFF;
			MODE_UP:   c = CODE_UP;
			MODE_RUN:  c = CODE_RUN;
			MODE_DOWN: c = CODE_DOWN;
			default:   c = CODE_OFF;
		endcase
		return c;
	endfunction

endpackage

/* src/ssrc_debounce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrc_debounce: one-shot button debouncer
// Fires once per press, on the tick at which the level has stayed low for the
// debounce time; rearms when the level goes high.
// ----------------------------------------------------------------------------
module ssrc_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          button_low,
	input  logic [ssrc_pkg::TIMER_W-1:0]  debounce_ticks,
	output logic                          fire
);
	import ssrc_pkg::*;

	logic               pending_q;
	logic               consumed_q;
	logic [TIMER_W-1:0] elapsed_q;
	logic               pending_d;
	logic               consumed_d;
	logic [TIMER_W-1:0] elapsed_d;

	// Work out this tick's press state
	always_comb begin
		pending_d  = pending_q;
		consumed_d = consumed_q;
		elapsed_d  = elapsed_q;
		fire       = 1'b0;
		if (!button_low) begin
			pending_d  = 1'b0;
			consumed_d = 1'b0;
		end else if (!pending_q && !consumed_q) begin
			pending_d = 1'b1;
			elapsed_d = '0;
		end else if (pending_q && !consumed_q) begin
			elapsed_d = sat_inc(elapsed_q);
			if (elapsed_d >= debounce_ticks) begin
				consumed_d = 1'b1;
				pending_d  = 1'b0;
				fire       = 1'b1;
			end
		end
	end

	// Hold the press state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			consumed_q <= 1'b0;
			elapsed_q  <= '0;
		end else if (tick) begin
			pending_q  <= pending_d;
			consumed_q <= consumed_d;
			elapsed_q  <= elapsed_d;
		end
	end

endmodule

/* src/soft_start_ramp_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_start_ramp_controller_top: soft-start ramp controller
// Four-state ramp machine with debounced toggle and kill buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in channel is one 1 us time-base tick carrying the
//   raw button levels and the start and stop requests. Each tick yields
//   exactly one result on the out channel: level, enable, LED, mode and the
//   one-tick on and off pulse flags.
//   The tick is taken into an input register, then updated and written into
//   the result register once that register is empty or being read. One
//   request per cycle is sustained while the receiver is ready; the state
//   update of one tick is a single pass of compares and increments.
//   When the receiver stalls, one tick waits in the input register and one
//   result in the output register; in_ready drops only when both are full.
//   Registers are written via the cfg channel (always ready); the user must
//   write them only while no tick is in flight; the block does not enforce it.
//   Reset sets off, level zero, rearms both debouncers, loads default timing.
// ----------------------------------------------------------------------------
module soft_start_ramp_controller_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ssrc_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ssrc_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssrc_pkg::TIMER_W-1:0]    cfg_data
);
	import ssrc_pkg::*;

	// Configuration registers
	logic [TIMER_W-1:0] debounce_q;
	logic [TIMER_W-1:0] interval_q;
	logic [LEVEL_W-1:0] steps_q;

	// Controller state
	mode_t              mode_q;
	logic [LEVEL_W-1:0] level_q;
	logic               enable_q;
	logic               led_q;
	logic [TIMER_W-1:0] ramp_q;

	// Pipeline
	logic  valid_s1;
	in_t   data_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  advance;

	logic  tog_fire;
	logic  kill_fire;

	mode_t              mode_d;
	logic [LEVEL_W-1:0] level_d;
	logic               enable_d;
	logic               led_d;
	logic [TIMER_W-1:0] ramp_d;
	logic               on_d;
	logic               off_d;
	logic [LEVEL_W:0]   next_up;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_INIT;
			interval_q <= INTERVAL_INIT;
			steps_q    <= STEPS_INIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_STEPS:    steps_q    <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	ssrc_debounce u_toggle (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (advance),
		.button_low     (data_s1.toggle_button_low),
		.debounce_ticks (debounce_q),
		.fire           (tog_fire)
	);

	ssrc_debounce u_kill (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (advance),
		.button_low     (data_s1.kill_button_low),
		.debounce_ticks (debounce_q),
		.fire           (kill_fire)
	);

	// Apply requests, button presses and one ramp step
	always_comb begin
		mode_d   = mode_q;
		level_d  = level_q;
		enable_d = enable_q;
		led_d    = led_q;
		ramp_d   = sat_inc(ramp_q);
		on_d     = 1'b0;
		off_d    = 1'b0;
		next_up  = '0;

		if (data_s1.start_request && mode_d == MODE_OFF) begin
			level_d  = '0;
			enable_d = 1'b1;
			ramp_d   = '0;
			mode_d   = MODE_UP;
			on_d     = 1'b1;
		end
		if (data_s1.stop_request && (mode_d == MODE_RUN || mode_d == MODE_UP)) begin
			ramp_d = '0;
			mode_d = MODE_DOWN;
			off_d  = 1'b1;
		end

		// Toggle: start when off, stop when running, ignore while ramping
		if (tog_fire) begin
			if (mode_d == MODE_OFF) begin
				level_d  = '0;
				enable_d = 1'b1;
				ramp_d   = '0;
				mode_d   = MODE_UP;
				on_d     = 1'b1;
			end else if (mode_d == MODE_RUN) begin
				ramp_d = '0;
				mode_d = MODE_DOWN;
				off_d  = 1'b1;
			end
		end

		// Kill: drop straight to off, leave the ramp timer alone
		if (kill_fire) begin
			level_d  = '0;
			enable_d = 1'b0;
			led_d    = 1'b0;
			mode_d   = MODE_OFF;
			off_d    = 1'b1;
		end

		// Ramp step
		if ((mode_d == MODE_UP || mode_d == MODE_DOWN) && ramp_d >= interval_q) begin
			ramp_d = '0;
			if (mode_d == MODE_UP) begin
				next_up = {1'b0, level_d} + (LEVEL_W+1)'(1);
				if (next_up >= {1'b0, steps_q}) begin
					level_d = steps_q;
					led_d   = 1'b1;
					mode_d  = MODE_RUN;
				end else begin
					level_d = next_up[LEVEL_W-1:0];
				end
			end else begin
				if (level_d <= LEVEL_W'(1)) begin
					level_d  = '0;
					enable_d = 1'b0;
					led_d    = 1'b0;
					mode_d   = MODE_OFF;
				end else begin
					level_d = level_d - LEVEL_W'(1);
				end
			end
		end
	end

	// Advance controller state once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			level_q  <= '0;
			enable_q <= 1'b0;
			led_q    <= 1'b0;
			ramp_q   <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			level_q  <= level_d;
			enable_q <= enable_d;
			led_q    <= led_d;
			ramp_q   <= ramp_d;
		end
	end

	// Hold the accepted request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.amplitude_level <= level_d;
			out_q.output_enabled  <= enable_d;
			out_q.led_on          <= led_d;
			out_q.device_mode     <= mode_code(mode_d);
			out_q.on_pulse        <= on_d;
			out_q.off_pulse       <= off_d;
		end
	end

endmodule
